@@ rtl/dsft_pkg.sv @@
`default_nettype none

package dsft_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;

    // Line byte kinds, also used as the back end's step codes.
    localparam kind_t KIND_START    = 3'd0;
    localparam kind_t KIND_ESCAPE   = 3'd1;
    localparam kind_t KIND_PAYLOAD  = 3'd2;
    localparam kind_t KIND_CHECKSUM = 3'd3;
    localparam kind_t KIND_END      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 2'd2;

    localparam byte_t START_CODE_RST  = 8'h02;
    localparam byte_t END_CODE_RST    = 8'h03;
    localparam byte_t ESCAPE_CODE_RST = 8'h10;

    typedef struct packed {
        byte_t start_code;
        byte_t end_code;
        byte_t escape_code;
    } cfg_t;

    // One classified payload item waiting for the back end.
    typedef struct packed {
        byte_t payload;
        byte_t checksum;
        logic  first;
        logic  escape;
        logic  last;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/dsft_front.sv @@
`default_nettype none

module dsft_front
    import dsft_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   accept,
    input  wire byte_t  payload_byte,
    input  wire logic   first_of_frame,
    input  wire logic   last_of_frame,
    output entry_t      entry
);

    byte_t sum_reg;
    byte_t sum_next;
    byte_t sum_base;
    byte_t sum_new;

    always_comb begin
        sum_base = first_of_frame ? '0 : sum_reg;
        sum_new  = sum_base + payload_byte;
        sum_next = sum_reg;
        if (accept) begin
            sum_next = last_of_frame ? '0 : sum_new;
        end
    end

    always_comb begin
        entry.payload  = payload_byte;
        entry.checksum = ~sum_new;
        entry.first    = first_of_frame;
        entry.escape   = (payload_byte == cfg.start_code) ||
                         (payload_byte == cfg.end_code) ||
                         (payload_byte == cfg.escape_code);
        entry.last     = last_of_frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dsft_queue.sv @@
`default_nettype none

module dsft_queue
    import dsft_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output entry_t      head
);

    entry_t     mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dsft_back.sv @@
`default_nettype none

module dsft_back
    import dsft_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   have_entry,
    input  wire entry_t head,
    output logic        pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output byte_t       m_tdata,
    output kind_t       m_tuser,
    output logic        m_tlast
);

    kind_t step_reg;
    kind_t step_next;
    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;
    kind_t kind_reg;
    logic  tlast_reg;

    logic  load;
    kind_t emit_kind;
    byte_t emit_byte;
    logic  emit_last;

    assign load = have_entry && (!valid_reg || m_tready);

    // Skip the start and escape steps that this item does not need.
    always_comb begin
        if (step_reg == KIND_START && head.first) begin
            emit_kind = KIND_START;
        end else if (step_reg <= KIND_ESCAPE && head.escape) begin
            emit_kind = KIND_ESCAPE;
        end else if (step_reg <= KIND_PAYLOAD) begin
            emit_kind = KIND_PAYLOAD;
        end else begin
            emit_kind = step_reg;
        end

        case (emit_kind)
            KIND_START:    emit_byte = cfg.start_code;
            KIND_ESCAPE:   emit_byte = cfg.escape_code;
            KIND_PAYLOAD:  emit_byte = head.payload;
            KIND_CHECKSUM: emit_byte = head.checksum;
            KIND_END:      emit_byte = cfg.end_code;
            default:       emit_byte = head.payload;
        endcase

        emit_last = (emit_kind == KIND_END) ||
                    (emit_kind == KIND_PAYLOAD && !head.last);
    end

    always_comb begin
        pop        = load && emit_last;
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            step_next  = emit_last ? KIND_START : emit_kind + kind_t'(1);
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg  <= emit_byte;
            kind_reg  <= emit_kind;
            tlast_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= KIND_START;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire

@@ rtl/dle_stuffed_frame_transmitter.sv @@
// Channel   Dir  Handshake           Contents
// s_        in   s_tvalid/s_tready   payload byte, first (tuser), last (tlast)
// m_        out  m_tvalid/m_tready   line byte, kind (tuser), end of run (tlast)
// cfg_      in   cfg_we              register index and 8-bit value
//
// The back end sends one line byte per cycle while m_tready is high; an item
// is one to five line bytes (one plus escape, plus start and plus checksum and
// end where marked). A two-entry queue parts the front from the back; items
// are taken while the queue has room and pass through the queue and then the
// back end's output register. Reset is synchronous and active low; it clears
// the running sum, queue, step counter and output valid and resets the codes.
`default_nettype none

module dle_stuffed_frame_transmitter
    import dsft_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] payload_byte
    input  wire logic [0:0]           s_tuser,   // [0] first_of_frame
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] line_byte
    output logic [2:0]                m_tuser,   // [2:0] byte_kind
    output logic                      m_tlast
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    entry_t front_entry;
    entry_t head;
    logic   accept;
    logic   q_full;
    logic   q_not_empty;
    logic   q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_START_CODE:  cfg_next.start_code  = cfg_wdata;
                CFG_END_CODE:    cfg_next.end_code    = cfg_wdata;
                CFG_ESCAPE_CODE: cfg_next.escape_code = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_code  <= START_CODE_RST;
            cfg_reg.end_code    <= END_CODE_RST;
            cfg_reg.escape_code <= ESCAPE_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    dsft_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .accept         (accept),
        .payload_byte   (s_tdata),
        .first_of_frame (s_tuser[0]),
        .last_of_frame  (s_tlast),
        .entry          (front_entry)
    );

    dsft_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    dsft_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .have_entry (q_not_empty),
        .head       (head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
